>>> sv/paf3_pkg.sv
package paf3_pkg;

    // fixed fraction of the point and result coordinates
    localparam int IO_FRAC = 16;
    // angle units: 1/16 degree
    localparam int FULL_TURN    = 5760;
    localparam int QUARTER_TURN = 1440;
    // width of a sum of four full products plus headroom
    localparam int SUM_W = 66;

    typedef logic signed [31:0] t_coord;
    typedef t_coord t_matrix [16];

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SCALE   = 3'd0,
        CFG_SHIFT_X = 3'd1,
        CFG_SHIFT_Y = 3'd2,
        CFG_SHIFT_Z = 3'd3,
        CFG_ANGLE_X = 3'd4,
        CFG_ANGLE_Y = 3'd5,
        CFG_ANGLE_Z = 3'd6
    } t_cfg_reg;

    // rebuild sequencer states
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_INDEX,
        SEQ_SCALE,
        SEQ_FETCH,
        SEQ_STORE,
        SEQ_MAC
    } t_seq_state;

    // pipeline control from the top level
    typedef struct packed {
        logic advance;
        logic load;
    } t_pipe_ctl;

    typedef struct packed {
        logic   hit;
        t_coord value;
    } t_sat;

    // clamp a wide signed value to 32 bits
    function automatic t_sat sat_coord(input logic signed [SUM_W-1:0] v);
        t_sat s;
        logic all_one;
        logic all_zero;
        all_one  = &v[SUM_W-1:31];
        all_zero = ~(|v[SUM_W-1:31]);
        if (all_one || all_zero) begin
            s.hit   = 1'b0;
            s.value = v[31:0];
        end else begin
            s.hit   = 1'b1;
            s.value = v[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s;
    endfunction

endpackage

>>> sv/paf3_sine_rom.sv
module paf3_sine_rom
    import paf3_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = 1024,
    parameter int FRACTION_BITS      = 16
) (
    input  logic                                      i_clk,
    input  logic [$clog2(SINE_TABLE_ENTRIES+1)-1:0]   i_addr,
    output logic [FRACTION_BITS:0]                    o_data
);

    typedef logic [FRACTION_BITS:0] t_rom [0:SINE_TABLE_ENTRIES];

    // quarter-wave sine by a taylor series in Q30, rounded to the table fraction
    function automatic t_rom build_rom();
        t_rom              t;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint            v;
        for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
            x    = 64'd1686629713 * 64'(k) / 64'(SINE_TABLE_ENTRIES);
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 3; n <= 15; n += 2) begin
                term = ((term * x2) >> 30) / 64'((n - 1) * n);
                if (((n >> 1) & 1) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            v = (sum + (64'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
            if (v > (64'sd1 <<< FRACTION_BITS)) begin
                v = 64'sd1 <<< FRACTION_BITS;
            end
            if (v < 0) begin
                v = 0;
            end
            t[k] = v[FRACTION_BITS:0];
        end
        return t;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    // registered read
    always_ff @(posedge i_clk) begin
        o_data <= SINE_ROM[i_addr];
    end

endmodule

>>> sv/paf3_rebuild.sv
module paf3_rebuild
    import paf3_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = 1024,
    parameter int FRACTION_BITS      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_matrix     o_matrix,
    output logic        o_busy
);

    localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int VW = $clog2(QUARTER_TURN * (SINE_TABLE_ENTRIES + 1));
    // reciprocal of a quarter turn, exact for every table position
    localparam longint DIV_SPAN = 64'(QUARTER_TURN) * 64'(QUARTER_TURN)
                                  * 64'(SINE_TABLE_ENTRIES + 1);
    localparam int     K        = $clog2(DIV_SPAN);
    localparam longint RECIP    = ((64'sd1 <<< K) + 64'(QUARTER_TURN - 1))
                                  / 64'(QUARTER_TURN);
    localparam int     RW       = $clog2(RECIP + 1);
    localparam int     MW       = VW + RW;
    localparam t_coord ONE_F    = t_coord'(32'd1 << FRACTION_BITS);
    localparam t_coord ONE_IO   = t_coord'(32'd1 << IO_FRAC);

    // configuration registers
    logic signed [23:0] r_scale;
    t_coord             r_shift [3];
    logic [12:0]        r_angle [3];

    // sequencer
    t_seq_state r_state, n_state;
    logic [2:0] r_lk;
    logic [1:0] r_phase;
    logic [3:0] r_e;
    logic [2:0] r_k;

    // trig lookup
    logic [VW-1:0]      r_v;
    logic [1:0]         r_quad;
    logic [IW-1:0]      r_idx;
    logic [FRACTION_BITS:0] rom_q;
    t_coord             r_trig [6];

    // matrix products
    t_matrix                  r_p;
    t_matrix                  r_r;
    t_matrix                  r_matrix;
    logic signed [63:0]       r_prod;
    logic signed [SUM_W-1:0]  r_acc;

    logic        cfg_ok;
    logic [12:0] c_ang_in;
    logic [12:0] c_ang;
    logic [1:0]  c_q;
    logic [10:0] c_rr;
    logic [VW-1:0] c_v;
    logic [MW-1:0] c_mul;
    logic [MW-1:0] c_shr;
    logic [IW-1:0] c_i;
    logic [IW-1:0] c_addr;
    t_coord      c_mag;
    t_coord      c_trig;
    logic [1:0]  row, col, kk;
    t_coord      op_a, op_b;
    logic signed [SUM_W-1:0] c_rnd;
    t_sat        c_sat;
    logic        trig_we;
    logic        mac_on;
    logic        entry_done;

    assign cfg_ok = i_cfg_we && (i_cfg_index <= CFG_ANGLE_Z);

    // angle wraps once into a full turn
    assign c_ang_in = (i_cfg_data[12:0] >= 13'(FULL_TURN))
                    ? i_cfg_data[12:0] - 13'(FULL_TURN) : i_cfg_data[12:0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 24'sd65536;
            for (int a = 0; a < 3; a++) begin
                r_shift[a] <= '0;
                r_angle[a] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SCALE:   r_scale    <= i_cfg_data[23:0];
                CFG_SHIFT_X: r_shift[0] <= i_cfg_data;
                CFG_SHIFT_Y: r_shift[1] <= i_cfg_data;
                CFG_SHIFT_Z: r_shift[2] <= i_cfg_data;
                CFG_ANGLE_X: r_angle[0] <= c_ang_in;
                CFG_ANGLE_Y: r_angle[1] <= c_ang_in;
                CFG_ANGLE_Z: r_angle[2] <= c_ang_in;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (cfg_ok) begin
            n_state = SEQ_INDEX;
        end else begin
            unique case (r_state)
                SEQ_IDLE:  n_state = SEQ_IDLE;
                SEQ_INDEX: n_state = SEQ_SCALE;
                SEQ_SCALE: n_state = SEQ_FETCH;
                SEQ_FETCH: n_state = SEQ_STORE;
                SEQ_STORE: n_state = (r_lk == 3'd5) ? SEQ_MAC : SEQ_INDEX;
                SEQ_MAC: begin
                    if (r_k == 3'd5 && r_e == 4'd15 && r_phase == 2'd2) begin
                        n_state = SEQ_IDLE;
                    end
                end
                default:   n_state = SEQ_IDLE;
            endcase
        end
    end

    // sequencer outputs
    always_comb begin
        o_busy     = (r_state != SEQ_IDLE);
        trig_we    = (r_state == SEQ_STORE);
        mac_on     = (r_state == SEQ_MAC);
        entry_done = (r_state == SEQ_MAC) && (r_k == 3'd5);
    end

    // sequencer counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_lk    <= '0;
            r_phase <= '0;
            r_e     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_ok) begin
                r_lk    <= '0;
                r_phase <= '0;
                r_e     <= '0;
                r_k     <= '0;
            end else begin
                if (trig_we) begin
                    r_lk <= (r_lk == 3'd5) ? 3'd0 : r_lk + 3'd1;
                end
                if (mac_on) begin
                    if (r_k == 3'd5) begin
                        r_k <= '0;
                        r_e <= r_e + 4'd1;
                        if (r_e == 4'd15) begin
                            r_phase <= r_phase + 2'd1;
                        end
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
            end
        end
    end

    // quadrant and remainder of the current angle; cosine is one quadrant on
    assign c_ang = r_angle[r_lk[2:1]];
    always_comb begin
        priority if (c_ang >= 13'(3 * QUARTER_TURN)) begin
            c_q  = 2'd3;
            c_rr = 11'(c_ang - 13'(3 * QUARTER_TURN));
        end else if (c_ang >= 13'(2 * QUARTER_TURN)) begin
            c_q  = 2'd2;
            c_rr = 11'(c_ang - 13'(2 * QUARTER_TURN));
        end else if (c_ang >= 13'(QUARTER_TURN)) begin
            c_q  = 2'd1;
            c_rr = 11'(c_ang - 13'(QUARTER_TURN));
        end else begin
            c_q  = 2'd0;
            c_rr = c_ang[10:0];
        end
    end

    assign c_v    = VW'(32'(c_rr) * 32'(SINE_TABLE_ENTRIES) + 32'(QUARTER_TURN / 2));
    assign c_mul  = MW'(r_v) * MW'(RECIP);
    assign c_shr  = c_mul >> K;
    assign c_i    = c_shr[IW-1:0];
    assign c_addr = r_quad[0] ? IW'(SINE_TABLE_ENTRIES) - c_i : c_i;

    // table position, then scaled index
    always_ff @(posedge i_clk) begin
        if (r_state == SEQ_INDEX) begin
            r_v    <= c_v;
            r_quad <= c_q + {1'b0, r_lk[0]};
        end
        if (r_state == SEQ_SCALE) begin
            r_idx <= c_addr;
        end
    end

    paf3_sine_rom #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
        .FRACTION_BITS      (FRACTION_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_idx),
        .o_data (rom_q)
    );

    assign c_mag  = t_coord'(32'(rom_q));
    assign c_trig = r_quad[1] ? -c_mag : c_mag;

    // sin x, cos x, sin y, cos y, sin z, cos z
    always_ff @(posedge i_clk) begin
        if (trig_we) begin
            r_trig[r_lk] <= c_trig;
        end
    end

    // rotation entry with the active plane u,v
    function automatic t_coord rot_entry(input logic [1:0] r, input logic [1:0] c,
                                         input logic [1:0] u, input logic [1:0] v,
                                         input t_coord sn, input t_coord cs);
        t_coord e;
        if ((r == u && c == u) || (r == v && c == v)) begin
            e = cs;
        end else if (r == u && c == v) begin
            e = -sn;
        end else if (r == v && c == u) begin
            e = sn;
        end else if (r == c) begin
            e = ONE_F;
        end else begin
            e = '0;
        end
        return e;
    endfunction

    assign row = r_e[3:2];
    assign col = r_e[1:0];
    assign kk  = r_k[1:0];

    // operands: Rx*Ry, then P*Rz, then A*R
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (r_phase)
            2'd0: begin
                op_a = rot_entry(row, kk, 2'd1, 2'd2, r_trig[0], r_trig[1]);
                op_b = rot_entry(kk, col, 2'd2, 2'd0, r_trig[2], r_trig[3]);
            end
            2'd1: begin
                op_a = r_p[{row, kk}];
                op_b = rot_entry(kk, col, 2'd0, 2'd1, r_trig[4], r_trig[5]);
            end
            2'd2: begin
                if (row == kk) begin
                    op_a = (row == 2'd3) ? ONE_IO : t_coord'(r_scale);
                end else if (row == 2'd3) begin
                    op_a = r_shift[kk];
                end
                op_b = r_r[{kk, col}];
            end
            default: ;
        endcase
    end

    // multiply and accumulate one entry over four products
    always_ff @(posedge i_clk) begin
        if (mac_on) begin
            if (r_k < 3'd4) begin
                r_prod <= op_a * op_b;
            end
            if (r_k == 3'd1) begin
                r_acc <= SUM_W'(r_prod);
            end else if (r_k >= 3'd2 && r_k <= 3'd4) begin
                r_acc <= r_acc + SUM_W'(r_prod);
            end
        end
    end

    assign c_rnd = (r_acc + (SUM_W'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    assign c_sat = sat_coord(c_rnd);

    // intermediate products
    always_ff @(posedge i_clk) begin
        if (entry_done && r_phase == 2'd0) begin
            r_p[r_e] <= c_sat.value;
        end
        if (entry_done && r_phase == 2'd1) begin
            r_r[r_e] <= c_sat.value;
        end
    end

    // composed matrix, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < 16; m++) begin
                r_matrix[m] <= (m % 5 == 0) ? ONE_IO : '0;
            end
        end else if (entry_done && r_phase == 2'd2) begin
            r_matrix[r_e] <= c_sat.value;
        end
    end

    assign o_matrix = r_matrix;

endmodule

>>> sv/paf3_datapath.sv
module paf3_datapath
    import paf3_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  t_coord    i_point [4],
    input  t_matrix   i_matrix,
    output logic      o_valid,
    output t_coord    o_out [4],
    output logic      o_clipped
);

    logic                    r_v1, r_v2, r_v3;
    logic signed [63:0]      r_prod [16];
    logic signed [SUM_W-1:0] r_sum [4];
    t_coord                  r_out [4];
    logic                    r_clip;

    logic signed [SUM_W-1:0] c_rnd [4];
    t_sat                    c_sat [4];
    logic                    c_clip;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_ctl.advance) begin
            r_v1 <= i_ctl.load;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 1: sixteen products of coordinate and matrix entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_prod[i*4+j] <= i_point[i] * i_matrix[i*4+j];
                end
            end
        end
    end

    // stage 2: column sums
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            for (int j = 0; j < 4; j++) begin
                r_sum[j] <= SUM_W'(r_prod[j]) + SUM_W'(r_prod[4+j])
                          + SUM_W'(r_prod[8+j]) + SUM_W'(r_prod[12+j]);
            end
        end
    end

    // stage 3: round half up to Q16.16 and saturate
    always_comb begin
        c_clip = 1'b0;
        for (int j = 0; j < 4; j++) begin
            c_rnd[j] = (r_sum[j] + (SUM_W'(1) <<< (IO_FRAC - 1))) >>> IO_FRAC;
            c_sat[j] = sat_coord(c_rnd[j]);
            c_clip   = c_clip | c_sat[j].hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            for (int j = 0; j < 4; j++) begin
                r_out[j] <= c_sat[j].value;
            end
            r_clip <= c_clip;
        end
    end

    assign o_valid   = r_v3;
    assign o_out     = r_out;
    assign o_clipped = r_clip;

endmodule

>>> sv/point_affine_transform_3d.sv
// channel   direction  handshake                   payload
// point     in         i_pt_valid / o_pt_ready     i_point_x/y/z/w
// result    out        o_res_valid / i_res_ready   o_out_x/y/z/w, o_clipped
// config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
// one point per cycle while no result waits and no rebuild runs; each result passes
// through registered products, column sums, and rounding and saturation
// synchronous active-low reset empties the pipeline and loads the identity matrix
// a register write rebuilds the matrix (six table lookups, then 48 entries on one
// shared multiplier); no item is taken meanwhile
// a waiting result holds the whole pipeline; nothing is lost or repeated
module point_affine_transform_3d
    import paf3_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = 1024,
    parameter int FRACTION_BITS      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_pt_valid,
    output logic        o_pt_ready,
    input  t_coord      i_point_x,
    input  t_coord      i_point_y,
    input  t_coord      i_point_z,
    input  t_coord      i_point_w,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_coord      o_out_x,
    output t_coord      o_out_y,
    output t_coord      o_out_z,
    output t_coord      o_out_w,
    output logic        o_clipped
);

    t_matrix   matrix;
    logic      busy;
    t_pipe_ctl ctl;
    t_coord    point [4];
    t_coord    res [4];

    paf3_rebuild #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
        .FRACTION_BITS      (FRACTION_BITS)
    ) u_rebuild (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_matrix    (matrix),
        .o_busy      (busy)
    );

    // pipeline moves unless a result waits
    assign ctl.advance = !o_res_valid || i_res_ready;
    assign o_pt_ready  = ctl.advance && !busy;
    assign ctl.load    = i_pt_valid && o_pt_ready;

    assign point[0] = i_point_x;
    assign point[1] = i_point_y;
    assign point[2] = i_point_z;
    assign point[3] = i_point_w;

    paf3_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_point   (point),
        .i_matrix  (matrix),
        .o_valid   (o_res_valid),
        .o_out     (res),
        .o_clipped (o_clipped)
    );

    assign o_out_x = res[0];
    assign o_out_y = res[1];
    assign o_out_z = res[2];
    assign o_out_w = res[3];

    // no item enters while the matrix is rebuilt
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_pt_ready)
        else $error("item taken during matrix rebuild");

    // a valid register write starts a rebuild
    a_write_rebuilds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index <= CFG_ANGLE_Z) |=> busy)
        else $error("register write did not start a rebuild");

    // a waiting result stops intake
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |-> !o_pt_ready)
        else $error("item taken while result stalled");

endmodule
